FILE: hw/rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Shared constants and helpers for the calendar date engine.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int unsigned AddDaysBitsDef = 16;
  localparam int unsigned AddDaysW       = 16;
  localparam int unsigned DayNumW        = 21;  // day numbers up to 1970..4096+
  localparam logic [11:0] EpochYear      = 12'd1970;
  localparam logic [11:0] MaxYear        = 12'd4095;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadDate = 2'd1;
  localparam logic [1:0] StatusOvf     = 2'd2;

  // Century test by reciprocal: y * 5243 >> 19 == y / 100, exact below 43690.
  function automatic logic is_leap(input logic [12:0] y);
    logic [25:0] prod;
    logic [6:0]  cent;
    logic        c4, c100, c400;
    prod = {13'd0, y} * 26'd5243;
    cent = prod[25:19];
    c4   = (y[1:0] == 2'd0);
    c100 = (({6'd0, cent} * 13'd100) == y);
    c400 = c100 && (cent[1:0] == 2'd0);
    return c4 && (!c100 || c400);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:                         r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      r = 5'd30;
      default:                      r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/calendar_date_engine.sv
// ----------------------------------------------------------------------------
// calendar_date_engine
// Checks a Gregorian date, adds a day count and gives weekday, week number,
// next workday and next Sunday.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake        | Beat
// in      | in  | in_valid_i/stall | in_year, in_month, in_day, add_days
// out     | out | out_valid_o/stall| status, weekday, week, three dates
//
// The shared adder/comparator walks year by year from 1970 to the input year,
// then month by month, then repeats the year and month walks for each of the
// three result dates, so the years walked set how long one beat takes.
// A malformed date is answered right after the edge that accepts it.
// Reset clears the sequencer and the output valid; payload is not reset.
// The input is stalled while a beat is in work or the result is unconsumed.
// ----------------------------------------------------------------------------
module calendar_date_engine
  import cde_pkg::*;
#(
  parameter int unsigned ADD_DAYS_BITS = AddDaysBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [11:0]              in_year_i,
  input  logic [3:0]               in_month_i,
  input  logic [4:0]               in_day_i,
  input  logic [AddDaysW-1:0]      add_days_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [2:0]               start_weekday_o,
  output logic [5:0]               week_number_o,
  output logic [11:0]              sum_year_o,
  output logic [3:0]               sum_month_o,
  output logic [4:0]               sum_day_o,
  output logic [11:0]              workday_year_o,
  output logic [3:0]               workday_month_o,
  output logic [4:0]               workday_day_o,
  output logic [11:0]              sunday_year_o,
  output logic [3:0]               sunday_month_o,
  output logic [4:0]               sunday_day_o
);

  // sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StYfwd  = 3'd1;  // day number of Jan 1 of input year
  localparam logic [2:0] StMfwd  = 3'd2;  // add months before input month
  localparam logic [2:0] StInfo  = 3'd3;  // weekday, week, targets
  localparam logic [2:0] StYdec  = 3'd4;  // decode target: years
  localparam logic [2:0] StMdec  = 3'd5;  // decode target: months
  localparam logic [2:0] StDone  = 3'd6;

  // only the low ADD_DAYS_BITS of the count are used
  localparam logic [AddDaysW-1:0] AddMask =
    (ADD_DAYS_BITS >= AddDaysW) ? {AddDaysW{1'b1}} :
                                  AddDaysW'((1 << ADD_DAYS_BITS) - 1);

  logic [2:0]          st_q, st_d;
  logic [11:0]         y_in_q;
  logic [3:0]          m_in_q;
  logic [4:0]          d_in_q;
  logic [AddDaysW-1:0] add_q;
  logic [12:0]         yc_q;       // walking year
  logic [3:0]          mc_q;       // walking month
  logic [DayNumW-1:0]  acc_q;      // running day number / remainder
  logic [DayNumW-1:0]  jan1_q;     // day number of Jan 1 of input year
  logic [DayNumW-1:0]  n_q;        // day number of input date
  logic [2:0]          wd_q;
  logic [2:0]          jwd_q;      // weekday of Jan 1 of walking year
  logic [1:0]          sel_q;      // which result date is being decoded
  logic                ovf_q;

  // shared unit: length of current year or month vs remainder
  logic                leap_c;
  logic [8:0]          ylen_c;
  logic [4:0]          mlen_c;
  logic [8:0]          span_c;
  logic                ge_c;
  logic [DayNumW-1:0]  sub_c;
  logic [DayNumW-1:0]  target_c;
  logic [DayNumW-1:0]  ord_c;
  logic [3:0]          jwd_sum_c;
  logic [2:0]          jwd_next_c;
  logic [8:0]          wsum_c;
  logic [17:0]         wprod_c;
  logic [5:0]          wq_c;
  logic [8:0]          wrem_c;
  logic                take_c;
  logic                bad_take_c;
  logic                out_valid_d;

  assign leap_c = is_leap(yc_q);
  assign ylen_c = leap_c ? 9'd366 : 9'd365;
  assign mlen_c = month_len(mc_q, leap_c);
  assign span_c = (st_q == StYfwd || st_q == StYdec) ? ylen_c : {4'd0, mlen_c};
  assign ge_c   = (acc_q >= DayNumW'(span_c));
  assign sub_c  = acc_q - DayNumW'(span_c);

  // Jan 1 weekday steps by 1 (or 2 after a leap year) per walked year
  assign jwd_sum_c  = {1'b0, jwd_q} + (leap_c ? 4'd2 : 4'd1);
  assign jwd_next_c = (jwd_sum_c >= 4'd7) ? 3'(jwd_sum_c - 4'd7) : jwd_sum_c[2:0];

  // (day of year + Jan 1 weekday) split by 7: x * 586 >> 12 == x / 7 below 682
  assign ord_c   = n_q - jan1_q;
  assign wsum_c  = ord_c[8:0] + {6'd0, jwd_q};
  assign wprod_c = {9'd0, wsum_c} * 18'd586;
  assign wq_c    = wprod_c[17:12];
  assign wrem_c  = wsum_c - {3'd0, wq_c} * 9'd7;

  always_comb begin
    unique case (sel_q)
      2'd0:    target_c = n_q + DayNumW'(add_q);
      2'd1:    target_c = n_q + ((wd_q == 3'd5) ? DayNumW'(3) :
                                 (wd_q == 3'd6) ? DayNumW'(2) : DayNumW'(1));
      default: target_c = n_q + DayNumW'(4'd7 - {1'b0, wd_q});
    endcase
  end

  logic date_ok_c;
  assign date_ok_c = (in_year_i >= EpochYear) && (in_month_i >= 4'd1) &&
                     (in_month_i <= 4'd12) && (in_day_i != 5'd0) &&
                     (in_day_i <= month_len(in_month_i, is_leap({1'b0, in_year_i})));

  assign in_stall_o = (st_q != StIdle) || out_valid_o;
  assign take_c     = in_valid_i && !in_stall_o;
  assign bad_take_c = take_c && !date_ok_c;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (take_c && date_ok_c) st_d = StYfwd;
      StYfwd:  if (yc_q[11:0] == y_in_q) st_d = StMfwd;
      StMfwd:  if (mc_q == m_in_q) st_d = StInfo;
      StInfo:  st_d = StYdec;
      StYdec:  if (!ge_c) st_d = StMdec;
               else if (yc_q == 13'(MaxYear)) st_d = StMdec;
      StMdec:  if (mc_q == 4'd12 || !ge_c) st_d = (sel_q == 2'd2) ? StDone : StYdec;
      StDone:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_o && out_stall_i;
    if (bad_take_c || st_q == StDone) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_o <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (take_c) begin
          y_in_q <= in_year_i;
          m_in_q <= in_month_i;
          d_in_q <= in_day_i;
          add_q  <= add_days_i & AddMask;
          yc_q   <= 13'(EpochYear);
          mc_q   <= 4'd1;
          acc_q  <= '0;
          jwd_q  <= 3'd4;  // 1970-01-01 was a Thursday
          sel_q  <= 2'd0;
          ovf_q  <= 1'b0;
          if (!date_ok_c) begin
            status_o        <= StatusBadDate;
            start_weekday_o <= '0;
            week_number_o   <= '0;
            sum_year_o <= '0; sum_month_o <= '0; sum_day_o <= '0;
            workday_year_o <= '0; workday_month_o <= '0; workday_day_o <= '0;
            sunday_year_o <= '0; sunday_month_o <= '0; sunday_day_o <= '0;
          end
        end
      end
      StYfwd: begin
        if (yc_q[11:0] != y_in_q) begin
          acc_q <= acc_q + DayNumW'(ylen_c);
          yc_q  <= yc_q + 13'd1;
          jwd_q <= jwd_next_c;
        end else begin
          jan1_q <= acc_q;
        end
      end
      StMfwd: begin
        if (mc_q != m_in_q) begin
          acc_q <= acc_q + DayNumW'(mlen_c);
          mc_q  <= mc_q + 4'd1;
        end else begin
          n_q <= acc_q + DayNumW'(d_in_q) - DayNumW'(1);
        end
      end
      StInfo: begin
        wd_q            <= wrem_c[2:0];
        start_weekday_o <= wrem_c[2:0];
        week_number_o   <= wq_c + 6'd1;
        acc_q <= target_c;
        yc_q  <= 13'(EpochYear);
        mc_q  <= 4'd1;
      end
      StYdec: begin
        if (ge_c) begin
          acc_q <= sub_c;
          yc_q  <= yc_q + 13'd1;
        end
      end
      StMdec: begin
        if (mc_q != 4'd12 && ge_c) begin
          acc_q <= sub_c;
          mc_q  <= mc_q + 4'd1;
        end else begin
          logic [11:0] ry;
          logic [3:0]  rm;
          logic [4:0]  rd;
          logic        bad;
          bad = yc_q[12];
          ry  = bad ? 12'd0 : yc_q[11:0];
          rm  = bad ? 4'd0 : mc_q;
          rd  = bad ? 5'd0 : 5'(acc_q + DayNumW'(1));
          if (bad) ovf_q <= 1'b1;
          unique case (sel_q)
            2'd0:    begin sum_year_o <= ry; sum_month_o <= rm; sum_day_o <= rd; end
            2'd1:    begin workday_year_o <= ry; workday_month_o <= rm;
                           workday_day_o <= rd; end
            default: begin sunday_year_o <= ry; sunday_month_o <= rm;
                           sunday_day_o <= rd; end
          endcase
          sel_q <= sel_q + 2'd1;
          acc_q <= (sel_q == 2'd0) ?
                   (n_q + ((wd_q == 3'd5) ? DayNumW'(3) :
                           (wd_q == 3'd6) ? DayNumW'(2) : DayNumW'(1))) :
                   (n_q + DayNumW'(4'd7 - {1'b0, wd_q}));
          yc_q <= 13'(EpochYear);
          mc_q <= 4'd1;
        end
      end
      StDone: status_o <= ovf_q ? StatusOvf : StatusOk;
      default: ;
    endcase
  end

endmodule
